[hw/rtl/bresenham_line_stepper_assert.svh]
// Assertion macros shared by the line stepper RTL.
`ifndef BRESENHAM_LINE_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_ASSERT_SVH

// Same-cycle implication check.
`define BLS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication check.
`define BLS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/bls_pkg.sv]
// Types and constants shared by the line stepper modules.
`default_nettype none

package bls_pkg;

   localparam int COORD_BITS = 12;
   // signed error term, two bits over a coordinate
   localparam int ERR_BITS   = COORD_BITS + 2;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last_pixel;
   } rsp_type;

   // classified work item handed from front to back
   typedef struct packed {
      logic                  is_load;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic                  x_down;
      logic                  y_down;
      logic [COORD_BITS-1:0] span_x;
      logic [COORD_BITS-1:0] span_y;
   } job_type;

endpackage

`default_nettype wire

[hw/rtl/bls_front.sv]
// Front end: classifies each request and works out line directions and spans.
`default_nettype none

module bls_front (
   input  var bls_pkg::req_type req_data,
   output var bls_pkg::job_type job
);

   logic x_down;
   logic y_down;

   // direction of travel on each axis
   assign x_down = req_data.end_x < req_data.start_x;
   assign y_down = req_data.end_y < req_data.start_y;

   // absolute spans and pass-through of endpoints
   always_comb begin
      job.is_load = (req_data.command == bls_pkg::CMD_LOAD);
      job.start_x = req_data.start_x;
      job.start_y = req_data.start_y;
      job.end_x   = req_data.end_x;
      job.end_y   = req_data.end_y;
      job.x_down  = x_down;
      job.y_down  = y_down;
      job.span_x  = x_down ? (req_data.start_x - req_data.end_x)
                           : (req_data.end_x - req_data.start_x);
      job.span_y  = y_down ? (req_data.start_y - req_data.end_y)
                           : (req_data.end_y - req_data.start_y);
   end

endmodule

`default_nettype wire

[hw/rtl/bls_queue.sv]
// Short job queue between the front end and the stepper.
`default_nettype none

module bls_queue #(
   parameter int DEPTH = 4
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  var bls_pkg::job_type  in_job,
   output logic                  out_valid,
   input  wire                   out_pop,
   output bls_pkg::job_type      out_job
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   bls_pkg::job_type      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff,  count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = count_ff < CNT_BITS'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;
   assign out_job   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

`include "bresenham_line_stepper_assert.svh"

   `BLS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(DEPTH))
   `BLS_ASSERT_NEXT(a_push_only, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `BLS_ASSERT_NOW(a_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

`default_nettype wire

[hw/rtl/bls_back.sv]
// Back end: Bresenham stepper state and the registered result stage.
`default_nettype none

module bls_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   job_valid,
   input  var bls_pkg::job_type  job,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output bls_pkg::rsp_type      rsp_data
);

   localparam int CB = bls_pkg::COORD_BITS;
   localparam int EB = bls_pkg::ERR_BITS;

   logic [CB-1:0]        cur_x_ff,  cur_x_in;
   logic [CB-1:0]        cur_y_ff,  cur_y_in;
   logic [CB-1:0]        goal_x_ff, goal_x_in;
   logic [CB-1:0]        goal_y_ff, goal_y_in;
   logic [CB-1:0]        span_x_ff, span_x_in;
   logic [CB-1:0]        span_y_ff, span_y_in;
   logic signed [EB-1:0] err_ff,    err_in;
   logic                 x_down_ff, x_down_in;
   logic                 y_down_ff, y_down_in;
   logic                 active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bls_pkg::rsp_type     rsp_data_ff,  rsp_data_in;

   logic                 load;
   logic                 emit;
   logic                 at_end;
   logic signed [EB:0]   doubled;
   logic signed [EB:0]   sx_wide;
   logic signed [EB:0]   sy_wide;
   logic                 move_x;
   logic                 move_y;
   logic signed [EB-1:0] err_step;

   // take a job whenever the result slot is free or draining
   assign job_pop = job_valid && (!rsp_valid_ff || rsp_ready);
   assign load    = job_pop && job.is_load;
   assign emit    = job_pop && !job.is_load && active_ff;
   assign at_end  = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);

   // error compare against the spans
   assign doubled  = {err_ff, 1'b0};
   assign sx_wide  = $signed({{(EB + 1 - CB){1'b0}}, span_x_ff});
   assign sy_wide  = $signed({{(EB + 1 - CB){1'b0}}, span_y_ff});
   assign move_x   = doubled > -sy_wide;
   assign move_y   = doubled < sx_wide;
   assign err_step = err_ff - (move_x ? sy_wide[EB-1:0] : '0)
                            + (move_y ? sx_wide[EB-1:0] : '0);

   // next state of the stepper and result stage
   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      err_in       = err_ff;
      x_down_in    = x_down_ff;
      y_down_in    = y_down_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         cur_x_in  = job.start_x;
         cur_y_in  = job.start_y;
         goal_x_in = job.end_x;
         goal_y_in = job.end_y;
         span_x_in = job.span_x;
         span_y_in = job.span_y;
         x_down_in = job.x_down;
         y_down_in = job.y_down;
         err_in    = $signed({2'b00, job.span_x}) - $signed({2'b00, job.span_y});
         active_in = 1'b1;
      end else if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.pixel_x     = cur_x_ff;
         rsp_data_in.pixel_y     = cur_y_ff;
         rsp_data_in.last_pixel  = at_end;
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            err_in = err_step;
            if (move_x) begin
               cur_x_in = x_down_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
            if (move_y) begin
               cur_y_in = y_down_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // line geometry and result payload
   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      goal_x_ff   <= goal_x_in;
      goal_y_ff   <= goal_y_in;
      span_x_ff   <= span_x_in;
      span_y_ff   <= span_y_in;
      err_ff      <= err_in;
      x_down_ff   <= x_down_in;
      y_down_ff   <= y_down_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "bresenham_line_stepper_assert.svh"

   `BLS_ASSERT_NEXT(a_load_arms, clock, reset, load, active_ff)
   `BLS_ASSERT_NEXT(a_last_idles, clock, reset, emit && at_end, !active_ff)
   `BLS_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid_ff)

endmodule

`default_nettype wire

[hw/rtl/bresenham_line_stepper.sv]
// Line stepper top level: front end, job queue and Bresenham back end.
//
// All-octant Bresenham line rasteriser. A load transfer (command 0) latches
// both endpoints and yields no result; each step transfer (command 1) then
// yields one pixel, from the start point through the end point, the last one
// flagged by last_pixel, after which steps yield nothing until the next load.
// A load mid-line abandons the current line. Sustained rate, while the result
// side does not stall, is one request per clock and one pixel per clock: the
// front end classifies a request in the cycle it is taken, and the back end
// retires one queued job per cycle, set by its error update and cursor step.
// A pixel passes through a queue entry and the registered result stage.
// The QUEUE_DEPTH-entry job queue absorbs stalls on the result side.
`default_nettype none

module bresenham_line_stepper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  var bls_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output bls_pkg::rsp_type     rsp_data
);

   bls_pkg::job_type front_job;
   bls_pkg::job_type head_job;
   logic             head_valid;
   logic             head_pop;

   bls_front u_front (
      .req_data (req_data),
      .job      (front_job)
   );

   bls_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_job    (front_job),
      .out_valid (head_valid),
      .out_pop   (head_pop),
      .out_job   (head_job)
   );

   bls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[bench/tb_bresenham_line_stepper.sv]
// Self-checking testbench for the Bresenham line stepper: directed table, then random lines.

module tb_bresenham_line_stepper;

   localparam int COORD_BITS    = bls_pkg::COORD_BITS;
   localparam int ERR_BITS      = bls_pkg::ERR_BITS;
   localparam int TOTAL_ITEMS   = 750;
   localparam int PRESS_AT      = 300;
   localparam int PAUSE_AT      = 500;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_REPORTS   = 10;
   localparam int TIMEOUT_UNITS = 3_000_000;
   localparam int COORD_TOP     = (1 << COORD_BITS) - 1;

   // one row of the directed table; pinned rows carry the pixel typed in by hand
   typedef struct packed {
      bls_pkg::req_type stim;
      logic             pinned;
      logic             pin_has;
      bls_pkg::rsp_type pin_pix;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   bls_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   bls_pkg::rsp_type rsp_data;

   // pixels still owed by the block, oldest first
   bls_pkg::rsp_type pending_pixels[$];

   // shadow of the rasteriser state
   logic [COORD_BITS-1:0]      pen_x, pen_y, aim_x, aim_y, run_x, run_y;
   logic signed [ERR_BITS-1:0] slope_err;
   logic                       x_dec, y_dec, drawing;

   // idling controls shared between processes
   bit sender_calm   = 1'b0;
   bit receiver_calm = 1'b0;
   bit hold_pending  = 1'b0;

   int faults         = 0;
   int pixels_checked = 0;
   int loads_sent     = 0;
   int steps_sent     = 0;
   int holds_done     = 0;

   bresenham_line_stepper i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #(TIMEOUT_UNITS);
      $display("timeout: %0d pixels still owed", pending_pixels.size());
      $display("tb_bresenham_line_stepper: done, errors");
      $finish;
   end

   function automatic void clear_trace();
      pen_x     = '0;
      pen_y     = '0;
      aim_x     = '0;
      aim_y     = '0;
      run_x     = '0;
      run_y     = '0;
      slope_err = '0;
      x_dec     = 1'b0;
      y_dec     = 1'b0;
      drawing   = 1'b0;
   endfunction

   // advance the shadow by one request; returns 1 when a pixel is owed
   function automatic bit trace_pixel(input bls_pkg::req_type r, output bls_pkg::rsp_type pix);
      int  twice;
      int  err;
      bit  at_end;
      pix = '0;
      if (r.command == bls_pkg::CMD_LOAD) begin
         pen_x     = r.start_x;
         pen_y     = r.start_y;
         aim_x     = r.end_x;
         aim_y     = r.end_y;
         x_dec     = r.end_x < r.start_x;
         y_dec     = r.end_y < r.start_y;
         run_x     = x_dec ? r.start_x - r.end_x : r.end_x - r.start_x;
         run_y     = y_dec ? r.start_y - r.end_y : r.end_y - r.start_y;
         slope_err = ERR_BITS'(int'(run_x) - int'(run_y));
         drawing   = 1'b1;
         return 1'b0;
      end
      // step with no line armed: nothing happens
      if (!drawing)
         return 1'b0;
      at_end         = (pen_x == aim_x) && (pen_y == aim_y);
      pix.pixel_x    = pen_x;
      pix.pixel_y    = pen_y;
      pix.last_pixel = at_end;
      if (at_end) begin
         drawing = 1'b0;
      end else begin
         err   = int'(slope_err);
         twice = 2 * err;
         if (twice > -int'(run_y)) begin
            err   = err - int'(run_y);
            pen_x = x_dec ? pen_x - 1'b1 : pen_x + 1'b1;
         end
         if (twice < int'(run_x)) begin
            err   = err + int'(run_x);
            pen_y = y_dec ? pen_y - 1'b1 : pen_y + 1'b1;
         end
         slope_err = ERR_BITS'(err);
      end
      return 1'b1;
   endfunction

   function automatic plan_row_type load_row(input int sx, input int sy, input int ex,
                                             input int ey);
      plan_row_type p;
      p               = '0;
      p.stim.command  = bls_pkg::CMD_LOAD;
      p.stim.start_x  = COORD_BITS'(sx);
      p.stim.start_y  = COORD_BITS'(sy);
      p.stim.end_x    = COORD_BITS'(ex);
      p.stim.end_y    = COORD_BITS'(ey);
      return p;
   endfunction

   // step rows carry all-ones coordinates, which the block must ignore
   function automatic plan_row_type step_row(input bit pinned, input bit has, input int px,
                                             input int py, input bit last);
      plan_row_type p;
      p                    = '0;
      p.stim.command       = bls_pkg::CMD_STEP;
      p.stim.start_x       = '1;
      p.stim.start_y       = '1;
      p.stim.end_x         = '1;
      p.stim.end_y         = '1;
      p.pinned             = pinned;
      p.pin_has            = has;
      p.pin_pix.pixel_x    = COORD_BITS'(px);
      p.pin_pix.pixel_y    = COORD_BITS'(py);
      p.pin_pix.last_pixel = last;
      return p;
   endfunction

   // random coordinate, leaning on the edges of the range now and then
   function automatic int pick_coord();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? COORD_TOP : 0;
      return $urandom_range(0, COORD_TOP);
   endfunction

   // end coordinate within reach of the start, kept inside the range
   function automatic int near_coord(input int base, input int reach);
      int v;
      if (reach >= COORD_TOP)
         return $urandom_range(0, COORD_TOP);
      v = base + $urandom_range(0, 2 * reach) - reach;
      if (v < 0)
         v = 0;
      if (v > COORD_TOP)
         v = COORD_TOP;
      return v;
   endfunction

   function automatic void flag_fault(input string what, input bls_pkg::rsp_type want,
                                      input bls_pkg::rsp_type got);
      faults++;
      if (faults <= MAX_REPORTS)
         $display("pixel %0d: %s: expected (%0d,%0d) last %0b, got (%0d,%0d) last %0b",
                  pixels_checked, what, want.pixel_x, want.pixel_y, want.last_pixel,
                  got.pixel_x, got.pixel_y, got.last_pixel);
   endfunction

   // offer one request, wait for its transfer, then record what it owes
   task automatic send_req(input bls_pkg::req_type r, input bit pinned, input bit pin_has,
                           input bls_pkg::rsp_type pin_pix);
      int               gap;
      bit               has;
      bls_pkg::rsp_type pix;
      gap = sender_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && req_ready));
      has = trace_pixel(r, pix);
      if (pinned) begin
         has = pin_has;
         pix = pin_pix;
      end
      if (has)
         pending_pixels.insert(pending_pixels.size(), pix);
      if (r.command == bls_pkg::CMD_LOAD)
         loads_sent++;
      else
         steps_sent++;
   endtask

   // stop offering and let every owed pixel come out
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : drain_side
      int stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            stall = receiver_calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // compare each result transfer against the oldest owed pixel
   always @(posedge clock) begin
      bls_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         pixels_checked++;
         if (pending_pixels.size() == 0) begin
            flag_fault("no pixel owed", '0, rsp_data);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_x !== want.pixel_x || rsp_data.pixel_y !== want.pixel_y ||
                rsp_data.last_pixel !== want.last_pixel)
               flag_fault("mismatch", want, rsp_data);
         end
      end
   end

   // stimulus
   initial begin : stimulus
      plan_row_type     directed_plan[$];
      bls_pkg::req_type r;
      int               sx, sy, ex, ey, reach, pixels, n, spread_x, spread_y;
      bit               pressed;
      bit               paused;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      pressed   = 1'b0;
      paused    = 1'b0;
      clear_trace();

      // step before any load, then single-point lines at both corners
      directed_plan = {directed_plan, step_row(1, 0, 0, 0, 0)};
      directed_plan = {directed_plan, load_row(0, 0, 0, 0)};
      directed_plan = {directed_plan, step_row(1, 1, 0, 0, 1)};
      directed_plan = {directed_plan, step_row(1, 0, 0, 0, 0)};
      directed_plan = {directed_plan, load_row(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP)};
      directed_plan = {directed_plan, step_row(1, 1, COORD_TOP, COORD_TOP, 1)};
      // shallow line run to its end, then one idle step
      directed_plan = {directed_plan, load_row(0, 0, 3, 1)};
      directed_plan = {directed_plan, step_row(1, 1, 0, 0, 0)};
      repeat (4) directed_plan = {directed_plan, step_row(0, 0, 0, 0, 0)};
      // full-range diagonal, abandoned by a load mid-line
      directed_plan = {directed_plan, load_row(0, COORD_TOP, COORD_TOP, 0)};
      directed_plan = {directed_plan, step_row(1, 1, 0, COORD_TOP, 0)};
      repeat (2) directed_plan = {directed_plan, step_row(0, 0, 0, 0, 0)};
      // x falling, y rising
      directed_plan = {directed_plan, load_row(10, 20, 7, 22)};
      directed_plan = {directed_plan, step_row(1, 1, 10, 20, 0)};
      repeat (3) directed_plan = {directed_plan, step_row(0, 0, 0, 0, 0)};
      // vertical, y falling
      directed_plan = {directed_plan, load_row(5, 9, 5, 5)};
      repeat (3) directed_plan = {directed_plan, step_row(0, 0, 0, 0, 0)};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i])
         send_req(directed_plan[i].stim, directed_plan[i].pinned, directed_plan[i].pin_has,
                  directed_plan[i].pin_pix);
      pause_until_drained();

      // random lines: load, then mostly the right number of steps
      while (loads_sent + steps_sent < TOTAL_ITEMS) begin
         sender_calm   = ($urandom_range(0, 5) == 0);
         receiver_calm = ($urandom_range(0, 5) == 0);

         if (!paused && loads_sent + steps_sent >= PAUSE_AT) begin
            paused = 1'b1;
            pause_until_drained();
         end

         if (!pressed && loads_sent + steps_sent >= PRESS_AT) begin
            // long line at full rate while the result side holds off
            pressed      = 1'b1;
            hold_pending = 1'b1;
            sender_calm  = 1'b1;
            sx = 2000;
            sy = 1000;
            ex = 2040;
            ey = 1013;
         end else begin
            reach = ($urandom_range(0, 9) == 0) ? COORD_TOP : $urandom_range(0, 12);
            sx = pick_coord();
            sy = pick_coord();
            ex = near_coord(sx, reach);
            ey = near_coord(sy, reach);
         end

         // occasional noise: steps with junk coordinates between lines
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               r.command = bls_pkg::CMD_STEP;
               r.start_x = COORD_BITS'($urandom);
               r.start_y = COORD_BITS'($urandom);
               r.end_x   = COORD_BITS'($urandom);
               r.end_y   = COORD_BITS'($urandom);
               send_req(r, 1'b0, 1'b0, '0);
            end
         end

         r.command = bls_pkg::CMD_LOAD;
         r.start_x = COORD_BITS'(sx);
         r.start_y = COORD_BITS'(sy);
         r.end_x   = COORD_BITS'(ex);
         r.end_y   = COORD_BITS'(ey);
         send_req(r, 1'b0, 1'b0, '0);

         spread_x = (ex > sx) ? ex - sx : sx - ex;
         spread_y = (ey > sy) ? ey - sy : sy - ey;
         pixels   = ((spread_x > spread_y) ? spread_x : spread_y) + 1;
         n        = pixels + $urandom_range(0, 2);
         // some lines are cut short by the next load
         if (!sender_calm && $urandom_range(0, 5) == 0)
            n = $urandom_range(0, pixels);
         if (n > 60)
            n = $urandom_range(1, 60);

         repeat (n) begin
            r.command = bls_pkg::CMD_STEP;
            r.start_x = COORD_BITS'($urandom);
            r.start_y = COORD_BITS'($urandom);
            r.end_x   = COORD_BITS'($urandom);
            r.end_y   = COORD_BITS'($urandom);
            send_req(r, 1'b0, 1'b0, '0);
         end
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads and %0d steps, %0d pixels compared, %0d long result hold",
               loads_sent, steps_sent, pixels_checked, holds_done);
      $display("all octants, single-point lines, idle steps and restarts mid-line; %0d faults",
               faults);
      if (faults == 0)
         $display("tb_bresenham_line_stepper: done, clean");
      else
         $display("tb_bresenham_line_stepper: done, errors");
      $finish;
   end

endmodule
